@@ sv/sac_pkg.sv @@
// Shared types and constants for the set-associative LRU tag cache.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package sac_pkg;

  localparam int MaxSetBits = 6;
  localparam int MaxWays    = 8;
  localparam int SetCount   = 1 << MaxSetBits;
  localparam int SetW       = MaxSetBits;
  localparam int WayW       = $clog2(MaxWays);
  localparam int RankW      = $clog2(MaxWays);
  localparam int TagW       = 64;
  localparam int TotalW     = 32;
  localparam int PaddrW     = 4;

  localparam logic [RankW-1:0] RankMax = RankW'(MaxWays - 1);

  typedef enum logic [1:0] {
    ActLoad   = 2'd0,
    ActStore  = 2'd1,
    ActModify = 2'd2,
    ActNone   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    RegSetBits = 2'd0,
    RegWays    = 2'd1,
    RegOffset  = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] address;
  } sac_in_t;

  typedef struct packed {
    logic              hit;
    logic              evicted;
    logic              last;
    logic [TotalW-1:0] hit_total;
    logic [TotalW-1:0] miss_total;
    logic [TotalW-1:0] eviction_total;
  } sac_out_t;

  typedef struct packed {
    logic             valid;
    logic [RankW-1:0] rank;
    logic [TagW-1:0]  tag;
  } way_t;

  typedef way_t [MaxWays-1:0] row_t;

  typedef struct packed {
    logic            found;
    logic [WayW-1:0] hit_way;
    logic            empty;
    logic [WayW-1:0] empty_way;
    logic [WayW-1:0] victim_way;
  } scan_res_t;

endpackage

`default_nettype wire

@@ sv/sac_row_mem.sv @@
// Set memory: one row per set holding valid bit, LRU rank and tag of every way.
// Depends on sac_pkg; rows not yet written read as all invalid with rank zero.
`default_nettype none

module sac_row_mem
  import sac_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            rd_en_i,
  input  wire logic [SetW-1:0] rd_addr_i,
  output row_t                 rd_row_o,
  input  wire logic            wr_en_i,
  input  wire logic [SetW-1:0] wr_addr_i,
  input  wire row_t            wr_row_i
);

  row_t                mem [SetCount];
  row_t                rdata_q;
  logic [SetCount-1:0] init_q;
  logic                rinit_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_row_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q  <= '0;
      rinit_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        init_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rinit_q <= init_q[rd_addr_i];
      end
    end
  end

  always_comb begin
    for (int w = 0; w < MaxWays; w++) begin
      rd_row_o[w].valid = rinit_q & rdata_q[w].valid;
      rd_row_o[w].rank  = rinit_q ? rdata_q[w].rank : '0;
      rd_row_o[w].tag   = rdata_q[w].tag;
    end
  end

endmodule

`default_nettype wire

@@ sv/sac_way_scan.sv @@
// Shared way scanner: one tag compare and one rank compare per cycle.
// Depends on sac_pkg; collects hit, first free way and LRU victim of a set.
`default_nettype none

module sac_way_scan
  import sac_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            step_i,
  input  wire logic [WayW-1:0] way_idx_i,
  input  wire way_t            way_i,
  input  wire logic [TagW-1:0] tag_i,
  output scan_res_t            res_o
);

  scan_res_t        res_q, res_d;
  logic [RankW-1:0] best_q, best_d;
  logic             first;
  logic             match;

  assign first = (way_idx_i == '0);
  assign match = way_i.valid && (way_i.tag == tag_i);

  always_comb begin
    res_d  = res_q;
    best_d = best_q;
    if (first) begin
      res_d.found = 1'b0;
      res_d.empty = 1'b0;
    end
    if (match && (first || !res_q.found)) begin
      res_d.found   = 1'b1;
      res_d.hit_way = way_idx_i;
    end
    if (!way_i.valid && (first || !res_q.empty)) begin
      res_d.empty     = 1'b1;
      res_d.empty_way = way_idx_i;
    end
    if (first || (way_i.rank > best_q)) begin
      best_d           = way_i.rank;
      res_d.victim_way = way_idx_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      res_q  <= res_d;
      best_q <= best_d;
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

@@ sv/set_assoc_lru_cache_tags.sv @@
// Top level of the set-associative LRU tag cache: sequencer, registers, totals.
// Depends on sac_pkg, sac_row_mem and sac_way_scan.
//
// Usage: an input item (action, address) enters on in_valid_i while in_stall_o
// is low. Load and store make one access and give one result item; modify
// makes two accesses and gives two, the second marked last. Action code 3 is
// dropped without a result. Each access reads its set row from memory,
// compares the ways one per cycle in the shared scanner, then writes the
// row back and loads the output register. The input is stalled while an
// item is in work. Results sit in an output register; a stalled receiver
// holds the block at the write-back step until the register drains, and the
// next item may be accepted while the last result still waits. After reset
// every line is invalid (per-set valid bits), totals are zero, and the
// registers hold set_index_bits 4, ways_in_use 1, offset_bits 4. The APB
// port is always ready.
`default_nettype none

module set_assoc_lru_cache_tags
  import sac_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire sac_in_t           in_item_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output sac_out_t               out_item_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [PaddrW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  typedef enum logic [3:0] {
    StIdle   = 4'b0001,
    StRead   = 4'b0010,
    StScan   = 4'b0100,
    StUpdate = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  action_e           act_q, act_d;
  logic [63:0]       addr_q, addr_d;
  logic              pass_q, pass_d;
  logic [SetW-1:0]   set_q, set_d;
  logic [TagW-1:0]   tag_q, tag_d;
  logic [WayW-1:0]   way_q, way_d;
  logic [TotalW-1:0] hits_q, misses_q, evicts_q;
  logic              out_valid_q;
  sac_out_t          out_item_q;
  logic [2:0]        sib_q;
  logic [3:0]        ways_q;
  logic [3:0]        off_q;

  logic              cfg_we;
  reg_idx_e          reg_idx;
  logic [2:0]        s_eff;
  logic [3:0]        ways_eff;
  logic [WayW-1:0]   last_way;
  logic [63:0]       shifted;
  logic [SetW-1:0]   set_mask;
  logic [SetW-1:0]   set_calc;
  logic [TagW-1:0]   tag_calc;

  row_t              rd_row;
  row_t              new_row;
  scan_res_t         res;
  logic [WayW-1:0]   pick_way;
  logic              pick_valid;
  logic [RankW-1:0]  old_rank;
  logic              evict;
  logic              adv;
  logic              is_last;
  logic [TotalW-1:0] hits_nx, misses_nx, evicts_nx;

  // Configuration port
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[3:2]);
  assign cfg_we  = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_idx)
      RegSetBits: prdata = {29'd0, sib_q};
      RegWays:    prdata = {28'd0, ways_q};
      RegOffset:  prdata = {28'd0, off_q};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sib_q  <= 3'd4;
      ways_q <= 4'd1;
      off_q  <= 4'd4;
    end else if (cfg_we) begin
      case (reg_idx)
        RegSetBits: sib_q  <= pwdata[2:0];
        RegWays:    ways_q <= pwdata[3:0];
        RegOffset:  off_q  <= pwdata[3:0];
        default:    ;
      endcase
    end
  end

  // Geometry
  assign s_eff    = (sib_q > 3'(MaxSetBits)) ? 3'(MaxSetBits) : sib_q;
  assign ways_eff = (ways_q == 4'd0) ? 4'd1 :
                    ((ways_q > 4'(MaxWays)) ? 4'(MaxWays) : ways_q);
  assign last_way = WayW'(ways_eff - 4'd1);
  assign shifted  = addr_q >> off_q;
  assign set_mask = ~({SetW{1'b1}} << s_eff);
  assign set_calc = shifted[SetW-1:0] & set_mask;
  assign tag_calc = shifted >> s_eff;

  sac_row_mem u_row_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (state_q == StRead),
    .rd_addr_i (set_calc),
    .rd_row_o  (rd_row),
    .wr_en_i   (adv),
    .wr_addr_i (set_q),
    .wr_row_i  (new_row)
  );

  sac_way_scan u_way_scan (
    .clk_i     (clk_i),
    .step_i    (state_q == StScan),
    .way_idx_i (way_q),
    .way_i     (rd_row[way_q]),
    .tag_i     (tag_q),
    .res_o     (res)
  );

  // Replacement choice and rank upkeep
  assign pick_way   = res.found ? res.hit_way : (res.empty ? res.empty_way : res.victim_way);
  assign pick_valid = res.found || !res.empty;
  assign old_rank   = rd_row[pick_way].rank;
  assign evict      = !res.found && !res.empty;

  always_comb begin
    new_row = rd_row;
    for (int v = 0; v < MaxWays; v++) begin
      if (WayW'(v) == pick_way) begin
        new_row[v].valid = 1'b1;
        new_row[v].rank  = '0;
        new_row[v].tag   = tag_q;
      end else if ((4'(v) < ways_eff) && rd_row[v].valid &&
                   (!pick_valid || (rd_row[v].rank < old_rank)) &&
                   (rd_row[v].rank != RankMax)) begin
        new_row[v].rank = rd_row[v].rank + 1'b1;
      end
    end
  end

  assign hits_nx   = (res.found && (hits_q != '1)) ? hits_q + 1'b1 : hits_q;
  assign misses_nx = (!res.found && (misses_q != '1)) ? misses_q + 1'b1 : misses_q;
  assign evicts_nx = (evict && (evicts_q != '1)) ? evicts_q + 1'b1 : evicts_q;
  assign is_last   = (act_q != ActModify) || pass_q;
  assign adv       = (state_q == StUpdate) && !(out_valid_q && out_stall_i);

  // Sequencer
  assign in_stall_o = (state_q != StIdle);

  always_comb begin
    state_d = state_q;
    act_d   = act_q;
    addr_d  = addr_q;
    pass_d  = pass_q;
    set_d   = set_q;
    tag_d   = tag_q;
    way_d   = way_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          act_d  = action_e'(in_item_i.action);
          addr_d = in_item_i.address;
          pass_d = 1'b0;
          if (action_e'(in_item_i.action) != ActNone) begin
            state_d = StRead;
          end
        end
      end
      StRead: begin
        set_d   = set_calc;
        tag_d   = tag_calc;
        way_d   = '0;
        state_d = StScan;
      end
      StScan: begin
        way_d = way_q + 1'b1;
        if (way_q == last_way) begin
          state_d = StUpdate;
        end
      end
      StUpdate: begin
        if (adv) begin
          if (is_last) begin
            state_d = StIdle;
          end else begin
            pass_d  = 1'b1;
            state_d = StRead;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      act_q       <= ActLoad;
      pass_q      <= 1'b0;
      way_q       <= '0;
      hits_q      <= '0;
      misses_q    <= '0;
      evicts_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      act_q   <= act_d;
      pass_q  <= pass_d;
      way_q   <= way_d;
      if (adv) begin
        hits_q      <= hits_nx;
        misses_q    <= misses_nx;
        evicts_q    <= evicts_nx;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    set_q  <= set_d;
    tag_q  <= tag_d;
    if (adv) begin
      out_item_q.hit            <= res.found;
      out_item_q.evicted        <= evict;
      out_item_q.last           <= is_last;
      out_item_q.hit_total      <= hits_nx;
      out_item_q.miss_total     <= misses_nx;
      out_item_q.eviction_total <= evicts_nx;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // The second access of a modify always finds its line.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && pass_q) |-> res.found)
    else $error("second modify access missed");

  // A result never reports both a hit and an eviction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_item_o.hit && out_item_o.evicted))
    else $error("hit and eviction in one result");

  // Write-back follows a scan that covered every way in use.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan && way_q == last_way) |=> (state_q == StUpdate))
    else $error("scan did not end in write-back");

  // The totals in each result equal the running totals once written back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> (out_item_o.hit_total == hits_q) && (out_item_o.miss_total == misses_q))
    else $error("result totals differ from running totals");

endmodule

`default_nettype wire

@@ tb/sac_checker.sv @@
// Checker for the set-associative LRU tag cache: watches the item channels and the APB port,
// keeps its own copy of the cache state and compares every result item in order.
// Depends on sac_pkg only.
`timescale 1ns / 1ps

module sac_checker
  import sac_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_stall_i,
  input  sac_in_t                in_item_i,
  input  wire logic              out_valid_i,
  input  wire logic              out_stall_i,
  input  sac_out_t               out_item_i,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [PaddrW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  input  wire logic              pready,
  output int                     fail_count_o,
  output int                     pending_o,
  output int                     results_o,
  output logic [31:0]            hits_o,
  output logic [31:0]            evictions_o
);

  localparam int LineCount = SetCount * MaxWays;
  localparam int ReportCap = 40;

  logic [2:0]  cfg_set_bits = 3'd4;
  logic [3:0]  cfg_ways     = 4'd1;
  logic [3:0]  cfg_offset   = 4'd4;

  logic        line_ok  [LineCount];
  logic [63:0] line_tag [LineCount];
  int unsigned line_rank[LineCount];
  logic [31:0] hits_seen;
  logic [31:0] misses_seen;
  logic [31:0] evictions_seen;

  sac_out_t    access_outcomes[$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    results_o    = 0;
  end

  assign hits_o      = hits_seen;
  assign evictions_o = evictions_seen;

  task automatic report(input string msg);
    fail_count_o++;
    if (fail_count_o <= ReportCap) $display("%0t ns: result %0d: %s", $time, results_o, msg);
  endtask

  task automatic clear_cache();
    for (int i = 0; i < LineCount; i++) begin
      line_ok[i]   = 1'b0;
      line_tag[i]  = '0;
      line_rank[i] = 0;
    end
    hits_seen      = '0;
    misses_seen    = '0;
    evictions_seen = '0;
    cfg_set_bits   = 3'd4;
    cfg_ways       = 4'd1;
    cfg_offset     = 4'd4;
    access_outcomes.delete();
  endtask

  task automatic cache_lookup(input logic [63:0] addr, input logic is_last);
    int unsigned s, ways, set_no, base, pick, old_rank;
    logic [63:0] tag;
    logic        found, empty, evict;
    sac_out_t    res;
    s      = (cfg_set_bits > MaxSetBits) ? MaxSetBits : cfg_set_bits;
    ways   = (cfg_ways == 0) ? 1 : ((cfg_ways > MaxWays) ? MaxWays : cfg_ways);
    set_no = 32'((addr >> cfg_offset) & ((64'd1 << s) - 64'd1));
    tag    = addr >> (cfg_offset + s);
    base   = set_no * MaxWays;
    found  = 1'b0;
    empty  = 1'b0;
    evict  = 1'b0;
    pick   = 0;
    for (int w = 0; w < ways; w++) begin
      if (!found && line_ok[base + w] && line_tag[base + w] == tag) begin
        found = 1'b1;
        pick  = w;
      end
    end
    if (found) begin
      if (hits_seen != '1) hits_seen++;
    end else begin
      if (misses_seen != '1) misses_seen++;
      for (int w = 0; w < ways; w++) begin
        if (!empty && !line_ok[base + w]) begin
          empty = 1'b1;
          pick  = w;
        end
      end
      if (!empty) begin
        pick = 0;
        for (int w = 1; w < ways; w++) begin
          if (line_rank[base + w] > line_rank[base + pick]) pick = w;
        end
        evict = 1'b1;
        if (evictions_seen != '1) evictions_seen++;
      end
    end
    old_rank = line_ok[base + pick] ? line_rank[base + pick] : 32'hFFFF_FFFF;
    for (int v = 0; v < ways; v++) begin
      if (v != pick && line_ok[base + v] && line_rank[base + v] < old_rank &&
          line_rank[base + v] < MaxWays - 1) line_rank[base + v]++;
    end
    line_rank[base + pick] = 0;
    line_ok[base + pick]   = 1'b1;
    line_tag[base + pick]  = tag;
    res.hit            = found;
    res.evicted        = evict;
    res.last           = is_last;
    res.hit_total      = hits_seen;
    res.miss_total     = misses_seen;
    res.eviction_total = evictions_seen;
    access_outcomes.push_back(res);
  endtask

  task automatic check_result(input sac_out_t got);
    sac_out_t want;
    if (access_outcomes.size() == 0) begin
      report("result item arrived with none outstanding");
    end else begin
      want = access_outcomes.pop_front();
      if (got.hit !== want.hit)
        report($sformatf("hit is %0b, predicted %0b", got.hit, want.hit));
      if (got.evicted !== want.evicted)
        report($sformatf("evicted is %0b, predicted %0b", got.evicted, want.evicted));
      if (got.last !== want.last)
        report($sformatf("last is %0b, predicted %0b", got.last, want.last));
      if (got.hit_total !== want.hit_total)
        report($sformatf("hit_total is %0d, predicted %0d", got.hit_total, want.hit_total));
      if (got.miss_total !== want.miss_total)
        report($sformatf("miss_total is %0d, predicted %0d", got.miss_total,
                         want.miss_total));
      if (got.eviction_total !== want.eviction_total)
        report($sformatf("eviction_total is %0d, predicted %0d", got.eviction_total,
                         want.eviction_total));
    end
    results_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_cache();
      pending_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[PaddrW-1:2])
          RegSetBits: cfg_set_bits = pwdata[2:0];
          RegWays:    cfg_ways     = pwdata[3:0];
          RegOffset:  cfg_offset   = pwdata[3:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) check_result(out_item_i);
      if (in_valid_i && !in_stall_i) begin
        case (in_item_i.action)
          ActLoad, ActStore: cache_lookup(in_item_i.address, 1'b1);
          ActModify: begin
            cache_lookup(in_item_i.address, 1'b0);
            cache_lookup(in_item_i.address, 1'b1);
          end
          default: ;
        endcase
      end
      pending_o <= access_outcomes.size();
    end
  end

endmodule

@@ tb/tb_set_assoc_lru_cache_tags.sv @@
// Top of the cache testbench: clock, reset, item and APB stimulus, receiver stalls and verdict.
// Depends on sac_pkg, set_assoc_lru_cache_tags and sac_checker.
`timescale 1ns / 1ps

module tb_set_assoc_lru_cache_tags;
  import sac_pkg::*;

  localparam int PhaseCount   = 13;
  localparam int PhaseItems   = 105;
  localparam int SettleCycles = 40;
  localparam int LongHold     = 400;
  localparam int DrainLimit   = 20000;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  sac_in_t           in_item_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  sac_out_t          out_item_o;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [PaddrW-1:0] paddr       = '0;
  logic [31:0]       pwdata      = '0;
  logic [31:0]       prdata;
  logic              pready;

  int          fail_count;
  int          pending;
  int          results;
  logic [31:0] hits;
  logic [31:0] evictions;

  int          items_sent    = 0;
  int          items_dropped = 0;
  int          settings      = 0;
  int          hold_requests = 0;
  int          holds_done    = 0;
  bit          tx_bursts_on  = 1'b1;
  bit          rx_bursts_on  = 1'b1;
  int unsigned eff_s         = 4;
  int unsigned eff_ways      = 1;
  int unsigned eff_off       = 4;
  int unsigned pool_used     = 3;
  logic [63:0] tag_pool[16];

  set_assoc_lru_cache_tags dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  sac_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_i  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .results_o   (results),
    .hits_o      (hits),
    .evictions_o (evictions)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #3_000_000;
    $display("Run timed out with %0d result items outstanding.", pending);
    $display("FAILURE");
    $finish;
  end

  initial begin : receiver
    int span;
    forever begin
      @(posedge clk_i);
      if (holds_done != hold_requests) begin
        holds_done++;
        out_stall_i <= 1'b1;
        repeat (LongHold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (rx_bursts_on && $urandom_range(0, 6) == 0) begin
        span = $urandom_range(1, 14);
        out_stall_i <= 1'b1;
        repeat (span) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic offer(input action_e act, input logic [63:0] addr);
    sac_in_t item;
    item.action  = act;
    item.address = addr;
    in_valid_i <= 1'b1;
    in_item_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
    if (act == ActNone) items_dropped++;
    if (tx_bursts_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PaddrW'(4 * int'(idx));
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_geometry(input int sb, input int wy, input int ob);
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    write_reg(RegSetBits, 32'(sb));
    write_reg(RegWays, 32'(wy));
    write_reg(RegOffset, 32'(ob));
    eff_s     = (sb > MaxSetBits) ? MaxSetBits : sb;
    eff_ways  = (wy == 0) ? 1 : ((wy > MaxWays) ? MaxWays : wy);
    eff_off   = ob;
    pool_used = eff_ways + 2;
    for (int i = 0; i < 16; i++) tag_pool[i] = (i % 2 == 0) ? 64'(i) : {$urandom, $urandom};
    settings++;
  endtask

  function automatic action_e pick_action();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return ActNone;
    if (r < 8) return ActLoad;
    if (r < 14) return ActStore;
    return ActModify;
  endfunction

  function automatic logic [63:0] pick_address();
    logic [63:0] set_mask, set_no, low;
    if ($urandom_range(0, 4) == 0) return {$urandom, $urandom};
    set_mask = (64'd1 << eff_s) - 64'd1;
    case ($urandom_range(0, 3))
      0:       set_no = 64'd0;
      1:       set_no = set_mask;
      2:       set_no = 64'd1 & set_mask;
      default: set_no = 64'($urandom) & set_mask;
    endcase
    low = 64'($urandom) & ((64'd1 << eff_off) - 64'd1);
    return (tag_pool[$urandom_range(0, pool_used - 1)] << (eff_off + eff_s)) |
           (set_no << eff_off) | low;
  endfunction

  initial begin : stimulus
    int counted;
    action_e act;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    offer(ActLoad, 64'h0);
    offer(ActLoad, 64'hF);
    offer(ActStore, 64'hFFFF_FFFF_FFFF_FFFF);
    offer(ActModify, 64'hFFFF_FFFF_FFFF_FFFF);
    offer(ActNone, 64'h5555_5555_5555_5555);
    offer(ActLoad, 64'h100);
    offer(ActModify, 64'h200);
    offer(ActLoad, 64'h0);
    offer(ActStore, 64'hAAAA_AAAA_AAAA_AAAA);
    offer(ActStore, 64'h5555_5555_5555_5555);
    offer(ActModify, 64'h8000_0000_0000_0000);
    offer(ActNone, 64'h0);
    set_geometry(0, 8, 0);
    for (int k = 1; k <= 9; k++) offer(ActLoad, 64'(k));
    offer(ActLoad, 64'h2);
    offer(ActStore, 64'hA);

    for (int ph = 0; ph < PhaseCount; ph++) begin
      case (ph)
        0:       set_geometry(0, 8, 0);
        1:       set_geometry(6, 8, 12);
        2:       set_geometry(7, 15, 15);
        3:       set_geometry(2, 0, 13);
        4:       set_geometry(1, 4, 3);
        5:       set_geometry(3, 2, 14);
        6:       set_geometry(5, 9, 1);
        7:       set_geometry(0, 3, 6);
        8:       set_geometry(6, 1, 0);
        9:       set_geometry(4, 1, 4);
        default: set_geometry($urandom_range(0, 7), $urandom_range(0, 15), $urandom_range(0, 15));
      endcase
      tx_bursts_on  = (ph % 4 != 1) && (ph < PhaseCount - 2);
      rx_bursts_on <= (ph % 4 != 1) && (ph < PhaseCount - 2);
      if (ph == 2) hold_requests++;
      counted = 0;
      while (counted < PhaseItems) begin
        act = pick_action();
        if (act != ActNone) counted++;
        offer(act, pick_address());
        if (ph == 5 && counted == PhaseItems / 2 && act != ActNone) wait_drained();
      end
    end

    in_valid_i <= 1'b0;
    for (int n = 0; n < DrainLimit && pending != 0; n++) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    $display("Sent %0d items (%0d with the unused action code) over %0d register settings.",
             items_sent, items_dropped, settings);
    $display("Checked %0d result items, predicting %0d hits and %0d evictions.",
             results, hits, evictions);
    if (pending != 0) $display("%0d predicted result items never arrived.", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
